// ===== hw/rtl/lifo_stack_with_dup_swap_over_defines.svh =====
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Shared assertion forms for the stack's checker.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_DUP_SWAP_OVER_DEFINES_SVH
`define LIFO_STACK_WITH_DUP_SWAP_OVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSDSO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSDSO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lsdso_pkg.sv =====
// ----------------------------------------------------------------------------
// LIFO stack package
// Operation and status codes and the field layout of the stream beats.
// ----------------------------------------------------------------------------
package lsdso_pkg;

   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;

   localparam int POPPED_LSB = 0;
   localparam int STATUS_LSB = POPPED_LSB + VALUE_W;
   localparam int COUNT_LSB  = STATUS_LSB + STATUS_W;
   localparam int RSP_USED_W = COUNT_LSB + COUNT_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 3'd0,
      KIND_POP  = 3'd1,
      KIND_DUP  = 3'd2,
      KIND_SWAP = 3'd3,
      KIND_OVER = 3'd4,
      KIND_DROP = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/lifo_stack_with_dup_swap_over.sv =====
// ----------------------------------------------------------------------------
// LIFO stack with dup, swap, over and drop
// Fixed-depth stack of data words driven by one operation per request beat.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock unless a stalled response holds
// it back; each gets one response beat, at full rate for any mix of
// operations. The top two elements live in registers and the element below
// them is prefetched from the stack memory every cycle into a third register,
// so that every operation, swap and pop included, is settled by one pass of
// logic between the request register and the response register; the single
// memory write port only takes the element that a push, dup or over moves down.
// Errors leave the stack untouched, and underflow is reported before overflow.
module lifo_stack_with_dup_swap_over #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // push_value[31:0]
   input  logic [lsdso_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind[2:0]
   input  logic [lsdso_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // popped_value[31:0], status[33:32], count[40:34], zero[47:41]
   output logic [lsdso_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import lsdso_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                  in_valid_ff;
   logic [KIND_W-1:0]     in_kind_ff;
   logic [DATA_WIDTH-1:0] in_value_ff;
   logic [DATA_WIDTH+VALUE_W-1:0] value_ext;

   logic [CW-1:0]         cnt_ff;
   logic [CW-1:0]         cnt_in;
   logic [DATA_WIDTH-1:0] top_ff;
   logic [DATA_WIDTH-1:0] top_in;
   logic [DATA_WIDTH-1:0] second_ff;
   logic [DATA_WIDTH-1:0] second_in;
   logic [DATA_WIDTH-1:0] third_ff;
   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic                  advance;
   logic                  spill;
   logic                  mem_we;
   logic [CW-1:0]         wr_cnt;
   logic [CW-1:0]         rd_base;
   logic [CW-1:0]         rd_cnt;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;

   logic                  is_empty;
   logic                  is_full;
   logic                  lt_two;
   status_type            status;
   logic [DATA_WIDTH-1:0] popped_word;
   logic [DATA_WIDTH+VALUE_W-1:0] popped_ext;
   logic [CW+COUNT_W-1:0] count_ext;

   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_popped_ff;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_tdata[VALUE_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_kind_ff  <= req_tuser[KIND_W-1:0];
         in_value_ff <= value_ext[DATA_WIDTH-1:0];
      end
   end

   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff == CW'(DEPTH));
   assign lt_two   = (cnt_ff < CW'(2));

   always_comb begin
      cnt_in      = cnt_ff;
      top_in      = top_ff;
      second_in   = second_ff;
      status      = ST_OK;
      popped_word = '0;
      spill       = 1'b0;
      case (kind_type'(in_kind_ff))
         KIND_PUSH: begin
            if (is_full) begin
               status = ST_OVER;
            end else begin
               top_in    = in_value_ff;
               second_in = top_ff;
               spill     = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         KIND_POP: begin
            if (is_empty) begin
               status = ST_UNDER;
            end else begin
               popped_word = top_ff;
               top_in      = second_ff;
               second_in   = third_ff;
               cnt_in      = cnt_ff - CW'(1);
            end
         end
         KIND_DUP: begin
            if (is_empty) begin
               status = ST_UNDER;
            end else if (is_full) begin
               status = ST_OVER;
            end else begin
               second_in = top_ff;
               spill     = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         KIND_SWAP: begin
            if (lt_two) begin
               status = ST_UNDER;
            end else begin
               top_in    = second_ff;
               second_in = top_ff;
            end
         end
         KIND_OVER: begin
            if (lt_two) begin
               status = ST_UNDER;
            end else if (is_full) begin
               status = ST_OVER;
            end else begin
               top_in    = second_ff;
               second_in = top_ff;
               spill     = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         KIND_DROP: begin
            if (is_empty) begin
               status = ST_UNDER;
            end else begin
               top_in    = second_ff;
               second_in = third_ff;
               cnt_in    = cnt_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // The second element moves into memory at its own index when the stack grows.
   assign mem_we    = advance && spill && !lt_two;
   assign wr_cnt    = cnt_ff - CW'(2);
   assign mem_waddr = wr_cnt[AW-1:0];
   assign rd_base   = advance ? cnt_in : cnt_ff;
   assign rd_cnt    = rd_base - CW'(3);
   assign mem_raddr = rd_cnt[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= second_ff;
      end
      if (mem_we && (mem_waddr == mem_raddr)) begin
         third_ff <= second_ff;
      end else begin
         third_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (advance) begin
         cnt_ff <= cnt_in;
      end
      if (advance) begin
         top_ff    <= top_in;
         second_ff <= second_in;
      end
   end

   assign popped_ext = {{VALUE_W{1'b0}}, popped_word};
   assign count_ext  = {{COUNT_W{1'b0}}, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_popped_ff <= popped_ext[VALUE_W-1:0];
         rsp_status_ff <= status;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_count_ff, rsp_status_ff,
                        rsp_popped_ff};

endmodule

// ===== hw/rtl/lsdso_checker.sv =====
// ----------------------------------------------------------------------------
// LIFO stack checker
// Port-level checks on the stack's response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_dup_swap_over_defines.svh"

module lsdso_checker #(
   parameter int DEPTH = 64
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lsdso_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import lsdso_pkg::*;

   logic [VALUE_W-1:0]  popped;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;
   logic                count_ok;

   assign popped   = rsp_tdata[POPPED_LSB +: VALUE_W];
   assign status   = rsp_tdata[STATUS_LSB +: STATUS_W];
   assign count    = rsp_tdata[COUNT_LSB +: COUNT_W];
   assign count_ok = (DEPTH > 127) || (int'(count) <= DEPTH);

   `LSDSO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "Stalled response beat changed.")
   `LSDSO_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, status == ST_OK || status == ST_UNDER || status == ST_OVER, "Response beat carries an unknown status.")
   `LSDSO_ASSERT_NOW(a_error_no_data, clock, reset, rsp_tvalid && status != ST_OK, popped == '0, "Failed operation returned a popped word.")
   `LSDSO_ASSERT_NOW(a_count_bound, clock, reset, rsp_tvalid, count_ok, "Element count exceeds the stack depth.")

endmodule

bind lifo_stack_with_dup_swap_over lsdso_checker #(
   .DEPTH(DEPTH)
) u_lsdso_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
